// ===== rtl/core/tfks_pkg.sv =====
// ---------------------------------------------------------------------------
// tfks_pkg
// Shared types, constants and round helpers for the threefry key split core.
// ---------------------------------------------------------------------------
package tfks_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned Rounds     = 20;
  localparam int unsigned Stages     = Rounds + 1;
  localparam int unsigned RoundWidth = 5;
  localparam int unsigned CountWidth = 5;

  localparam logic [WordWidth-1:0] KeyParity = 32'h1BD1_1BDA;

  typedef logic [WordWidth-1:0]  word_t;
  typedef logic [RoundWidth-1:0] round_t;
  typedef logic [4:0]            rot_t;
  typedef logic [1:0]            ksel_t;

  localparam ksel_t KselZero = 2'd0;
  localparam ksel_t KselOne  = 2'd1;
  localparam ksel_t KselTwo  = 2'd2;

  // working words plus the key schedule carried down the chain
  typedef struct packed {
    word_t x0;
    word_t x1;
    word_t k0;
    word_t k1;
    word_t k2;
  } state_t;

  function automatic rot_t rot_amount(input round_t r);
    rot_t amt;
    case (r[2:0])
      3'd0:    amt = 5'd13;
      3'd1:    amt = 5'd15;
      3'd2:    amt = 5'd26;
      3'd3:    amt = 5'd6;
      3'd4:    amt = 5'd17;
      3'd5:    amt = 5'd29;
      3'd6:    amt = 5'd16;
      default: amt = 5'd24;
    endcase
    return amt;
  endfunction

  function automatic word_t rotl(input word_t v, input rot_t d);
    logic [2*WordWidth-1:0] w;
    w = {v, v} << d;
    return w[2*WordWidth-1:WordWidth];
  endfunction

  // s mod 3 for the injection count s in 1..5
  function automatic ksel_t mod3(input logic [2:0] s);
    ksel_t m;
    case (s)
      3'd0, 3'd3, 3'd6: m = KselZero;
      3'd1, 3'd4, 3'd7: m = KselOne;
      default:          m = KselTwo;
    endcase
    return m;
  endfunction

  function automatic word_t key_pick(input state_t st, input ksel_t sel);
    word_t k;
    unique case (sel)
      KselZero: k = st.k0;
      KselOne:  k = st.k1;
      default:  k = st.k2;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/tfks_in_if.sv =====
// ---------------------------------------------------------------------------
// tfks_in_if
// Input channel: source key words and counter words.
// ---------------------------------------------------------------------------
interface tfks_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_first;
  logic [31:0] key_second;
  logic [31:0] counter_low;
  logic [31:0] counter_high;

  modport source (
    output valid, key_first, key_second, counter_low, counter_high,
    input  ready
  );
  modport sink (
    input  valid, key_first, key_second, counter_low, counter_high,
    output ready
  );
endinterface

// ===== rtl/core/tfks_out_if.sv =====
// ---------------------------------------------------------------------------
// tfks_out_if
// Output channel: derived key words.
// ---------------------------------------------------------------------------
interface tfks_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_first;
  logic [31:0] out_second;

  modport source (
    output valid, out_first, out_second,
    input  ready
  );
  modport sink (
    input  valid, out_first, out_second,
    output ready
  );
endinterface

// ===== rtl/core/tfks_key_cell.sv =====
// ---------------------------------------------------------------------------
// tfks_key_cell
// Head cell: forms the parity key word and the initial key injection.
// ---------------------------------------------------------------------------
module tfks_key_cell
  import tfks_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  word_t  key_first,
  input  word_t  key_second,
  input  word_t  counter_low,
  input  word_t  counter_high,
  output logic   dn_valid,
  input  logic   dn_ready,
  output state_t dn_data
);

  logic   valid;
  state_t data;
  state_t data_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    data_next.k0 = key_first;
    data_next.k1 = key_second;
    data_next.k2 = KeyParity ^ key_first ^ key_second;
    data_next.x0 = counter_low + key_first;
    data_next.x1 = counter_high + key_second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// ===== rtl/core/tfks_round_cell.sv =====
// ---------------------------------------------------------------------------
// tfks_round_cell
// One mix round, followed by a key injection after every fourth round.
// ---------------------------------------------------------------------------
module tfks_round_cell
  import tfks_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  round_t round_idx,
  input  logic   up_valid,
  output logic   up_ready,
  input  state_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output state_t dn_data
);

  logic       valid;
  state_t     data;
  state_t     data_next;
  logic [2:0] inj_count;
  word_t      mix_x0;
  word_t      mix_x1;

  assign up_ready  = !valid || dn_ready;
  // injection count s = round / 4 + 1
  assign inj_count = 3'(round_idx[RoundWidth-1:2]) + 3'd1;

  always_comb begin
    mix_x0    = up_data.x0 + up_data.x1;
    mix_x1    = rotl(up_data.x1, rot_amount(round_idx)) ^ mix_x0;
    data_next = up_data;
    if (round_idx[1:0] == 2'd3) begin
      data_next.x0 = mix_x0 + key_pick(up_data, mod3(inj_count));
      data_next.x1 = mix_x1 + key_pick(up_data, mod3(inj_count + 3'd1))
                     + WordWidth'(inj_count);
    end else begin
      data_next.x0 = mix_x0;
      data_next.x1 = mix_x1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// ===== rtl/core/threefry_key_split_core.sv =====
// ---------------------------------------------------------------------------
// threefry_key_split_core
// Threefry2x32 block function, 20 rounds, as a chain of registered cells.
// ---------------------------------------------------------------------------
// Takes one key/counter item per cycle unless stalled and returns the
// derived 64-bit key: a head cell does the initial key injection and
// twenty round cells follow, one round each, with the key schedule added
// in the cell that ends every group of four rounds. Each cell holds its
// item until the next one has room, so a stalled output stops the chain
// only where it is full; the last cell's register is the output register.
module threefry_key_split_core
  import tfks_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  tfks_in_if.sink    item,
  tfks_out_if.source result
);

  logic   valid_chain [Stages+1];
  logic   ready_chain [Stages+1];
  state_t data_chain  [Stages+1];

  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;

  tfks_key_cell u_key (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (item.valid),
    .up_ready     (item.ready),
    .key_first    (item.key_first),
    .key_second   (item.key_second),
    .counter_low  (item.counter_low),
    .counter_high (item.counter_high),
    .dn_valid     (valid_chain[1]),
    .dn_ready     (ready_chain[1]),
    .dn_data      (data_chain[1])
  );

  assign valid_chain[0] = item.valid;
  assign ready_chain[0] = item.ready;
  assign data_chain[0]  = '0;

  for (genvar i = 0; i < Rounds; i++) begin : g_round
    tfks_round_cell u_round (
      .clk       (clk),
      .rst       (rst),
      .round_idx (RoundWidth'(i)),
      .up_valid  (valid_chain[i+1]),
      .up_ready  (ready_chain[i+1]),
      .up_data   (data_chain[i+1]),
      .dn_valid  (valid_chain[i+2]),
      .dn_ready  (ready_chain[i+2]),
      .dn_data   (data_chain[i+2])
    );
  end

  assign result.valid      = valid_chain[Stages];
  assign ready_chain[Stages] = result.ready;
  assign result.out_first  = data_chain[Stages].x0;
  assign result.out_second = data_chain[Stages].x1;

  // items in flight, for checking only
  always_comb begin
    count_next = count;
    if (valid_chain[0] && ready_chain[0]) begin
      count_next = count_next + 1'b1;
    end
    if (result.valid && result.ready) begin
      count_next = count_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountWidth'(Stages))
    else $error("more items in flight than cells");

  a_empty_no_result: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !result.valid)
    else $error("result shown with no item in flight");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("input refused with empty output cell");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    count == CountWidth'(Stages) && !result.ready |-> !item.ready)
    else $error("input taken into a full stalled chain");

endmodule

// ===== verif/threefry_key_split_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// threefry_key_split_checker
// Scoreboard for the key split core. Every accepted key/counter transfer is
// run through a local Threefry2x32-20 model. Derived keys are compared word by
// word, in order, against the oldest pending prediction.
// ---------------------------------------------------------------------------
module threefry_key_split_checker
  import tfks_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tfks_in_if   item,
  tfks_out_if  result,
  input  logic end_check,
  output int   fail_count,
  output int   outstanding,
  output int   keys_checked
);

  localparam word_t ScheduleParity = 32'h1BD1_1BDA;
  localparam int    MaxReports     = 40;

  typedef struct packed {
    word_t first;
    word_t second;
  } derived_key_t;

  derived_key_t pending_keys [$];
  int           errors         = 0;
  int           checked        = 0;
  bit           leftovers_done = 1'b0;

  // rotations: 13,15,26,6 on even groups, 17,29,16,24 on odd groups
  function automatic int unsigned rot_distance(input int unsigned idx);
    int unsigned d;
    case (idx)
      0:       d = 13;
      1:       d = 15;
      2:       d = 26;
      3:       d = 6;
      4:       d = 17;
      5:       d = 29;
      6:       d = 16;
      default: d = 24;
    endcase
    return d;
  endfunction

  function automatic word_t word_rol(input word_t v, input int unsigned d);
    return (v << d) | (v >> (WordWidth - d));
  endfunction

  function automatic derived_key_t threefry_derive(input word_t key_a, input word_t key_b,
                                                   input word_t ctr_lo, input word_t ctr_hi);
    word_t        sched [3];
    word_t        x0;
    word_t        x1;
    int unsigned  inj;
    derived_key_t key;
    sched[0] = key_a;
    sched[1] = key_b;
    sched[2] = ScheduleParity ^ key_a ^ key_b;
    x0 = ctr_lo + sched[0];
    x1 = ctr_hi + sched[1];
    for (int unsigned grp = 0; grp < 5; grp++) begin
      for (int unsigned rnd = 0; rnd < 4; rnd++) begin
        x0 = x0 + x1;
        x1 = word_rol(x1, rot_distance((grp % 2) * 4 + rnd));
        x1 = x1 ^ x0;
      end
      inj = grp + 1;
      x0  = x0 + sched[inj % 3];
      x1  = x1 + sched[(inj + 1) % 3] + word_t'(inj);
    end
    key.first  = x0;
    key.second = x1;
    return key;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxReports) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    derived_key_t want;
    if (!rst) begin
      if (item.valid && item.ready) begin
        pending_keys.push_back(threefry_derive(item.key_first, item.key_second,
                                               item.counter_low, item.counter_high));
      end
      if (result.valid && result.ready) begin
        if (pending_keys.size() == 0) begin
          report_mismatch($sformatf("derived key %h_%h with no transfer pending",
                                    result.out_first, result.out_second));
        end else begin
          want = pending_keys.pop_front();
          checked++;
          if (result.out_first !== want.first) begin
            report_mismatch($sformatf("key %0d out_first got %h want %h",
                                      checked, result.out_first, want.first));
          end
          if (result.out_second !== want.second) begin
            report_mismatch($sformatf("key %0d out_second got %h want %h",
                                      checked, result.out_second, want.second));
          end
        end
      end
      if (end_check && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (pending_keys.size() != 0) begin
          report_mismatch($sformatf("%0d derived keys never came out", pending_keys.size()));
        end
      end
    end
    fail_count   <= errors;
    outstanding  <= pending_keys.size();
    keys_checked <= checked;
  end

endmodule

// ===== verif/threefry_key_split_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// threefry_key_split_core_tb
// Drives key/counter transfers into the key split core: first corner values
// back to back, then random keys and counters in bursts. Output backpressure
// varies, with one long hold-off that fills the chain. Checking is done by the
// scoreboard beside the core; this module gives the verdict.
// ---------------------------------------------------------------------------
module threefry_key_split_core_tb;
  import tfks_pkg::*;

  localparam int RandomItems = 1400;
  localparam int HoldAfter   = 500;   // input transfers before the long output hold-off
  localparam int HoldCycles  = 240;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 40;    // comfortably longer than the trip through the chain

  typedef enum logic [1:0] {PaceOpen, PaceCoin, PacePeriodic, PaceStarved} pace_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic end_check;
  int   fail_count;
  int   outstanding;
  int   keys_checked;
  int   items_accepted = 0;
  int   input_stalls   = 0;
  int   idle_cycles    = 0;
  int   items_offered  = 0;
  int   directed_items = 0;

  tfks_in_if  key_ch ();
  tfks_out_if derived_ch ();

  threefry_key_split_core DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (key_ch),
    .result (derived_ch)
  );

  threefry_key_split_checker key_check (
    .clk          (clk),
    .rst          (rst),
    .item         (key_ch),
    .result       (derived_ch),
    .end_check    (end_check),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .keys_checked (keys_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (derived_ch.valid && derived_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!rst && key_ch.valid && key_ch.ready) begin
      items_accepted <= items_accepted + 1;
    end
    if (!rst && key_ch.valid && !key_ch.ready) begin
      input_stalls <= input_stalls + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("threefry_key_split_core test failed");
      $finish;
    end
  end

  task automatic offer_key(input word_t key_a, input word_t key_b,
                           input word_t ctr_lo, input word_t ctr_hi);
    key_ch.valid        <= 1'b1;
    key_ch.key_first    <= key_a;
    key_ch.key_second   <= key_b;
    key_ch.counter_low  <= ctr_lo;
    key_ch.counter_high <= ctr_hi;
    items_offered++;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
  endtask

  // biased toward all-zero, all-one and single-bit words
  function automatic word_t edgy_word();
    int unsigned bit_pos;
    word_t       w;
    bit_pos = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = word_t'(1) << bit_pos;
      3:       w = ~(word_t'(1) << bit_pos);
      4:       w = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: w = $urandom();
    endcase
    return w;
  endfunction

  initial begin : out_pacing
    pace_mode_t mode;
    int         seg_left;
    int         phase;
    int         period;
    int         hold_left;
    bit         hold_done;
    mode      = PaceOpen;
    seg_left  = 0;
    phase     = 0;
    period    = 4;
    hold_left = 0;
    hold_done = 1'b0;
    derived_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        derived_ch.ready <= 1'b0;
      end else if (!hold_done && items_accepted >= HoldAfter) begin
        // long hold-off: the sender keeps offering until the chain backs up
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        derived_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = pace_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
          period   = $urandom_range(2, 9);
          phase    = 0;
        end
        seg_left--;
        phase++;
        case (mode)
          PaceOpen:     derived_ch.ready <= 1'b1;
          PaceCoin:     derived_ch.ready <= 1'($urandom_range(0, 1));
          PacePeriodic: derived_ch.ready <= ((phase % period) != 0);
          default:      derived_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    word_t key_a;
    word_t key_b;
    word_t ctr_lo;
    word_t ctr_hi;
    word_t split_index;
    int    burst_left;
    int    gap;
    rst                 <= 1'b1;
    end_check           <= 1'b0;
    key_ch.valid        <= 1'b0;
    key_ch.key_first    <= '0;
    key_ch.key_second   <= '0;
    key_ch.counter_low  <= '0;
    key_ch.counter_high <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // corner values, back to back
    offer_key('0, '0, '0, '0);
    offer_key('1, '1, '1, '1);
    offer_key('1, '0, '0, '0);
    offer_key('0, '1, '0, '0);
    offer_key('0, '0, '1, '0);
    offer_key('0, '0, '0, '1);
    offer_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    offer_key(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    offer_key(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer_key(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // third schedule word cancels to zero
    offer_key(32'h1234_5678, 32'h1234_5678 ^ KeyParity, '0, '0);
    offer_key(KeyParity, '0, '1, '1);
    offer_key('0, KeyParity, 32'h0000_0001, '1);
    // initial counter plus key wraps
    offer_key('1, '1, 32'h0000_0001, 32'h0000_0002);
    offer_key(32'h0000_0001, 32'h0000_0001, '1, '1);
    offer_key(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h2152_4111, 32'h3501_0FF3);
    for (int i = 0; i < 4; i++) begin
      offer_key(32'h0000_002A, 32'h0000_0000, word_t'(i), '0);
    end
    directed_items = items_offered;

    split_index = $urandom();
    burst_left  = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          key_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      key_a = edgy_word();
      key_b = ($urandom_range(0, 7) == 0) ? (key_a ^ KeyParity) : edgy_word();
      if ($urandom_range(0, 2) == 0) begin
        // consecutive split indices under the same high word
        ctr_lo      = split_index;
        ctr_hi      = '0;
        split_index = split_index + 1;
      end else begin
        ctr_lo = edgy_word();
        ctr_hi = edgy_word();
      end
      offer_key(key_a, key_b, ctr_lo, ctr_hi);
    end
    key_ch.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("ran %0d key/counter transfers (%0d corner, %0d random), %0d derived keys checked",
             items_accepted, directed_items, items_offered - directed_items, keys_checked);
    $display("input backpressure on %0d cycles, including a %0d-cycle output hold-off",
             input_stalls, HoldCycles);
    if (fail_count == 0) begin
      $display("threefry_key_split_core test passed");
    end else begin
      $display("threefry_key_split_core test failed");
    end
    $finish;
  end

endmodule
